[rtl/twss_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the timing wheel server scheduler
package twss_pkg;

    // Fixed field widths
    localparam int SERVER_W    = 5;
    localparam int QUERY_W     = 32;
    localparam int DELAY_W     = 7;
    localparam int CMD_W       = 2;
    localparam int CFG_W       = 6;
    localparam int MAX_DELAY_W = 6;
    localparam int REG_IDX_W   = 1;
    localparam int ALU_W       = 8;

    // Register reset values and fallback delay
    localparam logic [MAX_DELAY_W-1:0] MAX_DELAY_RST    = 6'd15;
    localparam logic [MAX_DELAY_W-1:0] DEFAULT_DELAY    = 6'd15;
    localparam logic [SERVER_W-1:0]    SERVER_COUNT_RST = 5'd4;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_MAX_DELAY    = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SERVER_COUNT = 1'b1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GRANT  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;
    localparam logic [1:0] KIND_GRANT   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_DELAY = 2'd1;
    localparam logic [1:0] ST_SLOT_FULL = 2'd2;
    localparam logic [1:0] ST_QUEUE     = 2'd3;

    // Adder operands
    localparam logic [ALU_W-1:0] ALU_ONE       = 8'd1;
    localparam logic [ALU_W-1:0] ALU_MINUS_ONE = 8'hFF;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [DELAY_W-1:0]  delay;
        logic [SERVER_W-1:0] server_num;
        logic [QUERY_W-1:0]  query_tag;
    } t_in_word;

    typedef struct packed {
        logic [1:0]          kind;
        logic [1:0]          status;
        logic [SERVER_W-1:0] out_server;
        logic [QUERY_W-1:0]  out_query;
        logic                last;
        logic                server_free;
    } t_out_word;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic [ALU_W-1:0] m;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             ge;
        logic [ALU_W-1:0] red;
    } t_alu_rsp;

    typedef struct packed {
        logic                load;
        logic [SERVER_W-1:0] load_num;
        logic                push;
        logic [SERVER_W-1:0] push_server;
        logic                pop;
    } t_fifo_ctl;

    typedef struct packed {
        logic                empty;
        logic                full;
        logic                one;
        logic [SERVER_W-1:0] head_server;
    } t_fifo_stat;

endpackage

[rtl/timing_wheel_server_scheduler_unit.sv]
`timescale 1ns / 1ps
// Timing wheel scheduler with a free-server queue. Words are taken one at a time and the
// block is busy until the last result word of the current one sits in the output register,
// which then waits for the consumer while the next word is accepted. All slot arithmetic
// (delay check, slot index, fill count, pointer advance) goes through one shared 8-bit
// add/compare unit, one operation per cycle, and the slot store has a registered read
// port. Slot fill counts are cleared at once by per-slot valid bits, so there is no
// clearing pass after reset or after max_delay is written.
module timing_wheel_server_scheduler_unit #(
    parameter int MAX_SLOTS   = 64,
    parameter int SLOT_DEPTH  = 8,
    parameter int MAX_SERVERS = 16,
    parameter int MIN_DELAY   = 1,
    parameter int QUERY_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  twss_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output twss_pkg::t_out_word                o_out_word,
    input  logic                               i_cfg_we,
    input  logic [twss_pkg::REG_IDX_W-1:0]     i_cfg_idx,
    input  logic [twss_pkg::CFG_W-1:0]         i_cfg_data
);

    // Only max_delay + 1 <= 64 slots can ever be used
    localparam int WHEEL_MAX = 1 << twss_pkg::MAX_DELAY_W;
    localparam int NSLOT     = (MAX_SLOTS < WHEEL_MAX) ? MAX_SLOTS : WHEEL_MAX;
    localparam int SW        = $clog2(NSLOT);
    localparam int NW        = $clog2(NSLOT + 1);
    localparam int EW        = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int FW        = $clog2(SLOT_DEPTH + 1);
    localparam int QSW       = (QUERY_WIDTH < twss_pkg::QUERY_W) ? QUERY_WIDTH
                                                                 : twss_pkg::QUERY_W;
    localparam int ENT_W     = twss_pkg::SERVER_W + QSW;
    localparam int ST_DEPTH  = NSLOT * (1 << EW);
    localparam int RST_N     = int'(twss_pkg::MAX_DELAY_RST) + 1;
    localparam int RST_NSLOT = (RST_N < NSLOT) ? RST_N : NSLOT;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_IDX,
        S_INS_WR,
        S_TCK_RD,
        S_TCK_FILL,
        S_TCK_ENT,
        S_TCK_REL,
        S_GNT,
        S_EMIT
    } t_state;

    // Registers
    t_state              r_state,   n_state;
    twss_pkg::t_in_word  r_in,      n_in;
    logic [NW-1:0]       r_nslot,   n_nslot;
    logic [SW-1:0]       r_cur,     n_cur;
    logic [SW-1:0]       r_ncur,    n_ncur;
    logic [SW-1:0]       r_idx,     n_idx;
    logic [FW-1:0]       r_cnt,     n_cnt;
    twss_pkg::t_out_word r_res,     n_res;
    logic [NSLOT-1:0]    r_valid,   n_valid;
    logic                r_o_valid, n_o_valid;
    twss_pkg::t_out_word r_o_word,  n_o_word;
    logic [SW-1:0]       r_fsel;

    // Memories
    logic [FW-1:0]       fill_mem  [NSLOT];
    logic [FW-1:0]       r_fill_rd;
    logic [ENT_W-1:0]    store_mem [ST_DEPTH];
    logic [ENT_W-1:0]    r_st_rd;

    logic                fill_we;
    logic [SW-1:0]       fill_ra;
    logic                st_we;
    logic [SW+EW-1:0]    st_wa;
    logic [SW+EW-1:0]    st_ra;
    logic [ENT_W-1:0]    st_wd;
    logic [FW-1:0]       fill_cur;

    twss_pkg::t_alu_req   alu_req;
    twss_pkg::t_alu_rsp   alu_rsp;
    twss_pkg::t_fifo_ctl  fifo_ctl;
    twss_pkg::t_fifo_stat fifo_stat;

    logic [twss_pkg::MAX_DELAY_W-1:0] cfg_d;
    logic [twss_pkg::MAX_DELAY_W:0]   cfg_n;
    logic [NW-1:0]                    cfg_nslot;
    logic                             out_free;
    logic                             in_take;

    logic [twss_pkg::SERVER_W-1:0]    rel_server;
    logic [QSW-1:0]                   rel_query;

    assign out_free   = !r_o_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_take    = i_in_valid && o_in_ready;

    assign rel_server = r_st_rd[ENT_W-1:QSW];
    assign rel_query  = r_st_rd[QSW-1:0];

    // Fill count of the slot read last cycle; an invalid slot is empty
    assign fill_cur = r_valid[r_fsel] ? r_fill_rd : '0;

    // Slot count from a max_delay write
    always_comb begin
        cfg_d = (i_cfg_data[twss_pkg::MAX_DELAY_W-1:0] >= twss_pkg::MAX_DELAY_W'(MIN_DELAY))
              ? i_cfg_data[twss_pkg::MAX_DELAY_W-1:0] : twss_pkg::DEFAULT_DELAY;
        cfg_n = {1'b0, cfg_d} + 1'b1;
        cfg_nslot = (cfg_n > (twss_pkg::MAX_DELAY_W + 1)'(NSLOT)) ? NW'(NSLOT) : NW'(cfg_n);
    end

    // Shared unit operand select
    always_comb begin
        alu_req = '0;
        case (r_state)
            S_INS_CHK: begin
                // ge: slot count >= delay
                alu_req.a = twss_pkg::ALU_W'(r_nslot);
                alu_req.m = twss_pkg::ALU_W'(r_in.delay);
            end
            S_INS_IDX: begin
                alu_req.a = twss_pkg::ALU_W'(r_cur);
                alu_req.b = twss_pkg::ALU_W'(r_in.delay);
                alu_req.m = twss_pkg::ALU_W'(r_nslot);
            end
            S_INS_WR: begin
                // ge: slot already full
                alu_req.a = twss_pkg::ALU_W'(fill_cur);
                alu_req.b = twss_pkg::ALU_ONE;
                alu_req.m = twss_pkg::ALU_W'(SLOT_DEPTH + 1);
            end
            S_TCK_RD: begin
                alu_req.a = twss_pkg::ALU_W'(r_cur);
                alu_req.b = twss_pkg::ALU_ONE;
                alu_req.m = twss_pkg::ALU_W'(r_nslot);
            end
            S_TCK_ENT: begin
                alu_req.a = twss_pkg::ALU_W'(r_cnt);
                alu_req.b = twss_pkg::ALU_MINUS_ONE;
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    twss_addcmp u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    twss_fifo #(
        .DEPTH (MAX_SERVERS)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fifo_ctl),
        .o_stat  (fifo_stat)
    );

    // Memory addresses and write data
    assign fill_ra = (r_state == S_INS_IDX) ? alu_rsp.red[SW-1:0] : r_cur;
    assign st_ra   = {r_cur, alu_rsp.sum[EW-1:0]};
    assign st_wa   = {r_idx, fill_cur[EW-1:0]};
    assign st_wd   = {r_in.server_num, r_in.query_tag[QSW-1:0]};

    // Sequencer next state
    always_comb begin
        n_state   = r_state;
        n_in      = r_in;
        n_nslot   = r_nslot;
        n_cur     = r_cur;
        n_ncur    = r_ncur;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_res     = r_res;
        n_valid   = r_valid;
        n_o_valid = r_o_valid && !i_out_ready;
        n_o_word  = r_o_word;
        fill_we   = 1'b0;
        st_we     = 1'b0;

        fifo_ctl             = '0;
        fifo_ctl.load        = i_cfg_we && (i_cfg_idx == twss_pkg::REG_SERVER_COUNT);
        fifo_ctl.load_num    = i_cfg_data[twss_pkg::SERVER_W-1:0];
        fifo_ctl.push_server = rel_server;

        // max_delay write empties the wheel
        if (i_cfg_we && (i_cfg_idx == twss_pkg::REG_MAX_DELAY)) begin
            n_nslot = cfg_nslot;
            n_valid = '0;
            n_cur   = '0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_in = i_in_word;
                    case (i_in_word.cmd)
                        twss_pkg::CMD_INSERT: n_state = S_INS_CHK;
                        twss_pkg::CMD_TICK:   n_state = S_TCK_RD;
                        twss_pkg::CMD_GRANT:  n_state = S_GNT;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end

            S_INS_CHK: begin
                n_res             = '0;
                n_res.kind        = twss_pkg::KIND_INSERT;
                n_res.last        = 1'b1;
                n_res.server_free = !fifo_stat.empty;
                if (!alu_rsp.ge || (r_in.delay < twss_pkg::DELAY_W'(MIN_DELAY))) begin
                    n_res.status = twss_pkg::ST_BAD_DELAY;
                    n_state      = S_EMIT;
                end else begin
                    n_state = S_INS_IDX;
                end
            end

            S_INS_IDX: begin
                n_idx   = alu_rsp.red[SW-1:0];
                n_state = S_INS_WR;
            end

            S_INS_WR: begin
                if (alu_rsp.ge) begin
                    n_res.status = twss_pkg::ST_SLOT_FULL;
                end else begin
                    n_res.status   = twss_pkg::ST_OK;
                    fill_we        = 1'b1;
                    st_we          = 1'b1;
                    n_valid[r_idx] = 1'b1;
                end
                n_state = S_EMIT;
            end

            S_TCK_RD: begin
                n_ncur  = alu_rsp.red[SW-1:0];
                n_state = S_TCK_FILL;
            end

            S_TCK_FILL: begin
                n_cnt = fill_cur;
                if (fill_cur == '0) begin
                    n_res             = '0;
                    n_res.kind        = twss_pkg::KIND_EMPTY;
                    n_res.last        = 1'b1;
                    n_res.server_free = !fifo_stat.empty;
                    n_valid[r_cur]    = 1'b0;
                    n_cur             = r_ncur;
                    n_state           = S_EMIT;
                end else begin
                    n_state = S_TCK_ENT;
                end
            end

            S_TCK_ENT: begin
                // newest entry first; store read issued here
                n_cnt   = alu_rsp.sum[FW-1:0];
                n_state = S_TCK_REL;
            end

            S_TCK_REL: begin
                fifo_ctl.push    = 1'b1;
                n_res.kind       = twss_pkg::KIND_RELEASE;
                n_res.status     = fifo_stat.full ? twss_pkg::ST_QUEUE : twss_pkg::ST_OK;
                n_res.out_server = rel_server;
                n_res.out_query  = twss_pkg::QUERY_W'(rel_query);
                n_res.last       = (r_cnt == '0);
                // after a push, or a refused one, the queue is never empty
                n_res.server_free = 1'b1;
                if (r_cnt == '0) begin
                    n_valid[r_cur] = 1'b0;
                    n_cur          = r_ncur;
                end
                n_state = S_EMIT;
            end

            S_GNT: begin
                fifo_ctl.pop      = 1'b1;
                n_res             = '0;
                n_res.kind        = twss_pkg::KIND_GRANT;
                n_res.last        = 1'b1;
                n_res.status      = fifo_stat.empty ? twss_pkg::ST_QUEUE : twss_pkg::ST_OK;
                n_res.out_server  = fifo_stat.empty ? '0 : fifo_stat.head_server;
                n_res.server_free = !fifo_stat.empty && !fifo_stat.one;
                n_state           = S_EMIT;
            end

            S_EMIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_word  = r_res;
                    n_state   = r_res.last ? S_IDLE : S_TCK_ENT;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, control and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_nslot   <= NW'(RST_NSLOT);
            r_cur     <= '0;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_nslot   <= n_nslot;
            r_cur     <= n_cur;
            r_valid   <= n_valid;
            r_o_valid <= n_o_valid;
        end
        r_in     <= n_in;
        r_ncur   <= n_ncur;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_res    <= n_res;
        r_o_word <= n_o_word;
        r_fsel   <= fill_ra;
    end

    // Slot fill counts
    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            fill_mem[r_idx] <= alu_rsp.sum[FW-1:0];
        end
        r_fill_rd <= fill_mem[fill_ra];
    end

    // Slot entries
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            store_mem[st_wa] <= st_wd;
        end
        r_st_rd <= store_mem[st_ra];
    end

    assign o_out_valid = r_o_valid;
    assign o_out_word  = r_o_word;

    // Wheel pointer stays inside the active slot range
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur < r_nslot)
        else $error("current slot outside wheel");

    // Handing over the final word of an item frees the input side
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && r_res.last) |=> o_in_ready)
        else $error("not ready after final word");

    // A released entry always leaves a server in the queue
    a_rel_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_word.kind == twss_pkg::KIND_RELEASE) |-> r_o_word.server_free)
        else $error("release word without free server");

    // Slot fill never exceeds the slot capacity
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TCK_FILL || r_state == S_INS_WR) |-> fill_cur <= FW'(SLOT_DEPTH))
        else $error("slot fill above capacity");

endmodule

[rtl/twss_addcmp.sv]
`timescale 1ns / 1ps
// Shared add / compare / reduce unit: sum = a + b, and sum - m when sum >= m
module twss_addcmp (
    input  twss_pkg::t_alu_req i_req,
    output twss_pkg::t_alu_rsp o_rsp
);

    logic [twss_pkg::ALU_W-1:0] sum;
    logic                       ge;

    assign sum = i_req.a + i_req.b;
    assign ge  = (sum >= i_req.m);

    assign o_rsp.sum = sum;
    assign o_rsp.ge  = ge;
    assign o_rsp.red = ge ? (sum - i_req.m) : sum;

endmodule

[rtl/twss_fifo.sv]
`timescale 1ns / 1ps
// Circular queue of free server numbers, reloaded with 1..n on reset or load
module twss_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  twss_pkg::t_fifo_ctl    i_ctl,
    output twss_pkg::t_fifo_stat   o_stat
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = (CW > twss_pkg::SERVER_W) ? CW : twss_pkg::SERVER_W;

    logic [twss_pkg::SERVER_W-1:0] r_entry [DEPTH];
    logic [PW-1:0]                 r_head;
    logic [PW-1:0]                 r_tail;
    logic [CW-1:0]                 r_count;

    logic [twss_pkg::SERVER_W-1:0] load_sel;
    logic [LW-1:0]                 load_ext;
    logic [CW-1:0]                 load_cnt;
    logic [PW-1:0]                 load_tail;
    logic                          is_full;
    logic                          is_empty;

    // Reload size, saturated at the queue depth
    assign load_sel  = i_rst_n ? i_ctl.load_num : twss_pkg::SERVER_COUNT_RST;
    assign load_ext  = LW'(load_sel);
    assign load_cnt  = (load_ext > LW'(DEPTH)) ? CW'(DEPTH) : CW'(load_ext);
    assign load_tail = (load_cnt == CW'(DEPTH)) ? '0 : PW'(load_cnt);

    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // Queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.load) begin
            r_head  <= '0;
            r_tail  <= load_tail;
            r_count <= load_cnt;
            for (int i = 0; i < DEPTH; i++) begin
                r_entry[i] <= twss_pkg::SERVER_W'(i + 1);
            end
        end else if (i_ctl.push && !is_full) begin
            r_entry[r_tail] <= i_ctl.push_server;
            r_tail          <= (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            r_count         <= r_count + 1'b1;
        end else if (i_ctl.pop && !is_empty) begin
            r_head  <= (r_head == PW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            r_count <= r_count - 1'b1;
        end
    end

    assign o_stat.empty       = is_empty;
    assign o_stat.full        = is_full;
    assign o_stat.one         = (r_count == CW'(1));
    assign o_stat.head_server = r_entry[r_head];

endmodule
